// ===== rtl/irpdt_pkg.sv =====
package irpdt_pkg;

  // Default data bits per frame
  localparam int FRAME_BITS_DEF = 32;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MARK    = 3'd6;

  // Register reset values
  localparam logic [7:0]  HALF_PERIOD_RST  = 8'd12;
  localparam logic [15:0] BIT_MARK_RST     = 16'd560;
  localparam logic [15:0] ONE_SPACE_RST    = 16'd1690;
  localparam logic [15:0] ZERO_SPACE_RST   = 16'd560;
  localparam logic [15:0] HEADER_MARK_RST  = 16'd9000;
  localparam logic [15:0] HEADER_SPACE_RST = 16'd4500;
  localparam logic [15:0] STOP_MARK_RST    = 16'd560;

  // Request operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HMARK  = 3'd1,
    PH_HSPACE = 3'd2,
    PH_BMARK  = 3'd3,
    PH_BSPACE = 3'd4,
    PH_STOP   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0]  half_period;
    logic [15:0] bit_mark;
    logic [15:0] one_space;
    logic [15:0] zero_space;
    logic [15:0] header_mark;
    logic [15:0] header_space;
    logic [15:0] stop_mark;
  } cfg_t;

  // Segment chosen by the skip logic
  typedef struct packed {
    phase_t      phase;
    logic [15:0] len;
    logic        mark;
  } seg_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] address;
    logic [15:0] command;
  } in_item_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_end;
    logic send_taken;
  } out_item_t;

endpackage

// ===== rtl/irpdt_cfg.sv =====
module irpdt_cfg
  import irpdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD:  cfg_nxt.half_period  = cfg_wdata[7:0];
        REG_BIT_MARK:     cfg_nxt.bit_mark     = cfg_wdata;
        REG_ONE_SPACE:    cfg_nxt.one_space    = cfg_wdata;
        REG_ZERO_SPACE:   cfg_nxt.zero_space   = cfg_wdata;
        REG_HEADER_MARK:  cfg_nxt.header_mark  = cfg_wdata;
        REG_HEADER_SPACE: cfg_nxt.header_space = cfg_wdata;
        REG_STOP_MARK:    cfg_nxt.stop_mark    = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period  <= HALF_PERIOD_RST;
      cfg_r.bit_mark     <= BIT_MARK_RST;
      cfg_r.one_space    <= ONE_SPACE_RST;
      cfg_r.zero_space   <= ZERO_SPACE_RST;
      cfg_r.header_mark  <= HEADER_MARK_RST;
      cfg_r.header_space <= HEADER_SPACE_RST;
      cfg_r.stop_mark    <= STOP_MARK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/irpdt_settle.sv =====
module irpdt_settle
  import irpdt_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  localparam int IDX_W = $clog2(FRAME_BITS)
) (
  input  phase_t                 st_phase,
  input  logic [IDX_W-1:0]       st_idx,
  input  logic [FRAME_BITS-1:0]  word,
  input  cfg_t                   cfg,
  output seg_t                   seg,
  output logic [IDX_W-1:0]       seg_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

  logic                  one_nz;
  logic                  zero_nz;
  logic                  bm_nz;
  logic [FRAME_BITS-1:0] space_nz;
  logic [IDX_W-1:0]      top_idx;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  phase_t                stop_ph;
  phase_t                ph;
  logic [IDX_W-1:0]      idx;

  assign one_nz  = (cfg.one_space != 16'd0);
  assign zero_nz = (cfg.zero_space != 16'd0);
  assign bm_nz   = (cfg.bit_mark != 16'd0);
  assign stop_ph = (cfg.stop_mark != 16'd0) ? PH_STOP : PH_IDLE;

  // Bits whose space is not empty
  always_comb begin
    for (int j = 0; j < FRAME_BITS; j++) begin
      space_nz[j] = word[j] ? one_nz : zero_nz;
    end
  end

  // Highest non-empty space at or below the entry bit
  assign top_idx = (st_phase == PH_HMARK || st_phase == PH_HSPACE) ? LAST_IDX : st_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = 0; j < FRAME_BITS; j++) begin
      if (space_nz[j] && (IDX_W'(j) <= top_idx)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

  // Skip empty segments from the entry point on
  always_comb begin
    ph  = PH_IDLE;
    idx = st_idx;
    unique case (st_phase)
      PH_IDLE: begin
        ph = PH_IDLE;
      end
      PH_HMARK, PH_HSPACE, PH_BMARK: begin
        if (st_phase == PH_HMARK && cfg.header_mark != 16'd0) begin
          ph = PH_HMARK;
        end else if (st_phase != PH_BMARK && cfg.header_space != 16'd0) begin
          ph = PH_HSPACE;
        end else if (bm_nz) begin
          ph  = PH_BMARK;
          idx = top_idx;
        end else if (hit) begin
          ph  = PH_BSPACE;
          idx = hit_idx;
        end else begin
          ph  = stop_ph;
          idx = '0;
        end
      end
      PH_BSPACE: begin
        if (space_nz[st_idx]) begin
          ph = PH_BSPACE;
        end else if (!bm_nz) begin
          ph  = hit ? PH_BSPACE : stop_ph;
          idx = hit ? hit_idx : '0;
        end else if (st_idx == '0) begin
          ph = stop_ph;
        end else begin
          ph  = PH_BMARK;
          idx = st_idx - 1'b1;
        end
      end
      PH_STOP: begin
        ph = stop_ph;
      end
      default: begin
        ph = PH_IDLE;
      end
    endcase
  end

  // Length of the landed segment
  always_comb begin
    seg.phase = ph;
    seg.mark  = (ph == PH_HMARK || ph == PH_BMARK || ph == PH_STOP);
    unique case (ph)
      PH_HMARK:  seg.len = cfg.header_mark;
      PH_HSPACE: seg.len = cfg.header_space;
      PH_BMARK:  seg.len = cfg.bit_mark;
      PH_BSPACE: seg.len = word[idx] ? cfg.one_space : cfg.zero_space;
      PH_STOP:   seg.len = cfg.stop_mark;
      default:   seg.len = 16'd0;
    endcase
  end

  assign seg_idx = idx;

endmodule

// ===== rtl/irpdt_engine.sv =====
module irpdt_engine
  import irpdt_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  localparam int IDX_W = $clog2(FRAME_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

  phase_t                phase_r, phase_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [15:0]           seg_left_r, seg_left_nxt;
  logic [7:0]            carr_cnt_r, carr_cnt_nxt;
  logic                  carr_lvl_r, carr_lvl_nxt;
  logic [FRAME_BITS-1:0] word_r, word_nxt;

  logic [FRAME_BITS+31:0] word_ext;
  logic [FRAME_BITS-1:0]  new_word;
  logic                   start;
  logic                   idle;
  logic                   mark_now;
  logic [7:0]             hp;
  logic [7:0]             cnt_inc;
  logic [15:0]            seg_dec;
  phase_t                 adv_phase;
  logic [IDX_W-1:0]       adv_idx;
  phase_t                 st_phase;
  logic [IDX_W-1:0]       st_idx;
  logic [FRAME_BITS-1:0]  st_word;
  seg_t                   seg;
  logic [IDX_W-1:0]       seg_idx;

  assign word_ext = {{FRAME_BITS{1'b0}}, item.address, item.command};
  assign new_word = word_ext[FRAME_BITS-1:0];
  assign start    = (item.operation == OP_START);
  assign idle     = (phase_r == PH_IDLE);
  assign mark_now = (phase_r == PH_HMARK || phase_r == PH_BMARK || phase_r == PH_STOP);
  assign hp       = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
  assign cnt_inc  = carr_cnt_r + 8'd1;
  assign seg_dec  = seg_left_r - 16'd1;

  // Segment after the one that just ran out
  always_comb begin
    adv_phase = PH_IDLE;
    adv_idx   = idx_r;
    unique case (phase_r)
      PH_HMARK:  adv_phase = PH_HSPACE;
      PH_HSPACE: begin
        adv_phase = PH_BMARK;
        adv_idx   = LAST_IDX;
      end
      PH_BMARK:  adv_phase = PH_BSPACE;
      PH_BSPACE: begin
        if (idx_r == '0) begin
          adv_phase = PH_STOP;
        end else begin
          adv_phase = PH_BMARK;
          adv_idx   = idx_r - 1'b1;
        end
      end
      default:   adv_phase = PH_IDLE;
    endcase
  end

  // Entry point for the skip logic
  assign st_phase = start ? PH_HMARK : adv_phase;
  assign st_idx   = start ? LAST_IDX : adv_idx;
  assign st_word  = start ? new_word : word_r;

  irpdt_settle #(
    .FRAME_BITS (FRAME_BITS)
  ) u_settle (
    .st_phase (st_phase),
    .st_idx   (st_idx),
    .word     (st_word),
    .cfg      (cfg),
    .seg      (seg),
    .seg_idx  (seg_idx)
  );

  // Step the frame by one request
  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    seg_left_nxt = seg_left_r;
    carr_cnt_nxt = carr_cnt_r;
    carr_lvl_nxt = carr_lvl_r;
    word_nxt     = word_r;
    res          = '0;
    if (start) begin
      if (idle) begin
        word_nxt       = new_word;
        phase_nxt      = seg.phase;
        idx_nxt        = seg_idx;
        seg_left_nxt   = seg.len;
        res.send_taken = 1'b1;
        res.busy_res   = (seg.phase != PH_IDLE);
        if (seg.mark) begin
          carr_cnt_nxt = 8'd0;
          carr_lvl_nxt = 1'b1;
        end
      end else begin
        res.busy_res = 1'b1;
      end
    end else if (!idle) begin
      res.busy_res = 1'b1;
      if (mark_now) begin
        res.ir_level = carr_lvl_r;
        if (cnt_inc >= hp) begin
          carr_cnt_nxt = 8'd0;
          carr_lvl_nxt = !carr_lvl_r;
        end else begin
          carr_cnt_nxt = cnt_inc;
        end
      end
      seg_left_nxt = seg_dec;
      if (seg_dec == 16'd0) begin
        phase_nxt     = seg.phase;
        idx_nxt       = seg_idx;
        seg_left_nxt  = seg.len;
        res.frame_end = (seg.phase == PH_IDLE);
        if (seg.mark) begin
          carr_cnt_nxt = 8'd0;
          carr_lvl_nxt = 1'b1;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      idx_r      <= '0;
      seg_left_r <= '0;
      carr_cnt_r <= '0;
      carr_lvl_r <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      seg_left_r <= seg_left_nxt;
      carr_cnt_r <= carr_cnt_nxt;
      carr_lvl_r <= carr_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      word_r <= word_nxt;
    end
  end

  // A frame end leaves the engine idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.frame_end |=> phase_r == PH_IDLE)
    else $error("frame end without return to idle");

  // The emitter is only driven during a mark
  a_level_mark: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.ir_level |-> mark_now && !start)
    else $error("emitter on outside a mark");

  // A running segment is never empty
  a_seg_nz: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> seg_left_r != 16'd0)
    else $error("empty segment in progress");

  // A taken send only comes from idle
  a_taken_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.send_taken |-> idle && start)
    else $error("send taken while busy");

endmodule

// ===== rtl/ir_pulse_distance_transmitter_top.sv =====
// Channel | Ports                              | Moves
// in      | in_valid, in_ready, in_data        | tick or start request
// out     | out_valid, out_ready, out_data     | one result per request
// cfg     | cfg_we, cfg_index, cfg_wdata       | register write, no wait
//
// A request is held in the input register, then the engine updates the
// frame state and loads the result register.
// Sustained rate is one request per cycle while out_ready stays high.
// Reset is synchronous and active low; no clearing pass is needed.
// With out_ready low the result holds, the input register fills, then in_ready drops.
module ir_pulse_distance_transmitter_top
  import irpdt_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  in_item_t  s1_item_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_item_t out_item_r;
  logic      out_valid_r, out_valid_nxt;
  logic      s1_adv;
  cfg_t      cfg;
  out_item_t res;

  irpdt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irpdt_engine #(
    .FRAME_BITS (FRAME_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Advance when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture request and result payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Every request that leaves the input register shows up as a result
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced request lost");

  // A waiting result blocks the input register from advancing
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !s1_adv)
    else $error("result overwritten");

endmodule

// ===== tb/ir_frame_monitor.sv =====
module ir_frame_monitor
  import irpdt_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_total,
  output int                    results_owed,
  output logic                  frame_busy
);

  // Shadow copy of the timing registers and the frame state
  cfg_t        regs;
  phase_t      phase_q;
  int          bit_idx;
  logic [15:0] seg_left;
  int          car_cnt;
  logic        car_lvl;
  logic [63:0] word;

  // Line results still owed by the block, oldest first
  out_item_t   queued_results[$];

  function automatic bit is_mark(phase_t ph);
    return ph == PH_HMARK || ph == PH_BMARK || ph == PH_STOP;
  endfunction

  function automatic logic [15:0] seg_length(phase_t ph);
    case (ph)
      PH_HMARK:  return regs.header_mark;
      PH_HSPACE: return regs.header_space;
      PH_BMARK:  return regs.bit_mark;
      PH_BSPACE: return word[bit_idx] ? regs.one_space : regs.zero_space;
      PH_STOP:   return regs.stop_mark;
      default:   return '0;
    endcase
  endfunction

  function void step_phase();
    case (phase_q)
      PH_HMARK:  phase_q = PH_HSPACE;
      PH_HSPACE: begin
        phase_q = PH_BMARK;
        bit_idx = FRAME_BITS - 1;
      end
      PH_BMARK:  phase_q = PH_BSPACE;
      PH_BSPACE: begin
        if (bit_idx == 0) begin
          phase_q = PH_STOP;
        end else begin
          bit_idx--;
          phase_q = PH_BMARK;
        end
      end
      default:   phase_q = PH_IDLE;
    endcase
  endfunction

  // Walk forward to the next segment with a nonzero length
  function void enter_segments();
    while (phase_q != PH_IDLE) begin
      seg_left = seg_length(phase_q);
      if (is_mark(phase_q)) begin
        car_lvl = 1'b1;
        car_cnt = 0;
      end
      if (seg_left != 0) return;
      step_phase();
    end
    seg_left = '0;
  endfunction

  // Advance the frame by one request and return the line result it causes
  function out_item_t transmit_step(in_item_t req);
    out_item_t res;
    int        hp;
    res = '0;
    if (req.operation == OP_START) begin
      if (phase_q == PH_IDLE) begin
        word = {32'd0, req.address, req.command};
        if (FRAME_BITS < 64) word = word & ((64'd1 << FRAME_BITS) - 64'd1);
        bit_idx = FRAME_BITS - 1;
        phase_q = PH_HMARK;
        enter_segments();
        res.send_taken = 1'b1;
      end
      res.busy_res = (phase_q != PH_IDLE);
    end else if (phase_q != PH_IDLE) begin
      hp = (regs.half_period == 0) ? 1 : int'(regs.half_period);
      res.busy_res = 1'b1;
      if (is_mark(phase_q)) begin
        res.ir_level = car_lvl;
        car_cnt++;
        if (car_cnt >= hp) begin
          car_cnt = 0;
          car_lvl = ~car_lvl;
        end
      end
      seg_left = seg_left - 16'd1;
      if (seg_left == 0) begin
        step_phase();
        enter_segments();
        if (phase_q == PH_IDLE) res.frame_end = 1'b1;
      end
    end
    return res;
  endfunction

  function void log_failure(string why, out_item_t want, out_item_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $write("%s: expected level=%0b busy=%0b end=%0b taken=%0b, ",
             why, want.ir_level, want.busy_res, want.frame_end, want.send_taken);
      $display("got level=%0b busy=%0b end=%0b taken=%0b",
               got.ir_level, got.busy_res, got.frame_end, got.send_taken);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs = '{HALF_PERIOD_RST, BIT_MARK_RST, ONE_SPACE_RST, ZERO_SPACE_RST,
               HEADER_MARK_RST, HEADER_SPACE_RST, STOP_MARK_RST};
      phase_q = PH_IDLE;
      bit_idx = 0;
      seg_left = '0;
      car_cnt = 0;
      car_lvl = 1'b0;
      word = '0;
      queued_results.delete();
      fail_total = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_PERIOD:  regs.half_period  = cfg_wdata[7:0];
          REG_BIT_MARK:     regs.bit_mark     = cfg_wdata;
          REG_ONE_SPACE:    regs.one_space    = cfg_wdata;
          REG_ZERO_SPACE:   regs.zero_space   = cfg_wdata;
          REG_HEADER_MARK:  regs.header_mark  = cfg_wdata;
          REG_HEADER_SPACE: regs.header_space = cfg_wdata;
          REG_STOP_MARK:    regs.stop_mark    = cfg_wdata;
          default: ;
        endcase
      end
      // Compare each delivered result against the oldest prediction
      if (out_valid && out_ready) begin
        if (queued_results.size() == 0) begin
          log_failure("result with nothing pending", '0, out_data);
        end else begin
          want = queued_results.pop_front();
          if (out_data.ir_level !== want.ir_level || out_data.busy_res !== want.busy_res ||
              out_data.frame_end !== want.frame_end ||
              out_data.send_taken !== want.send_taken)
            log_failure("result mismatch", want, out_data);
        end
      end
      // Predict the result of each accepted request
      if (in_valid && in_ready) queued_results.push_back(transmit_step(in_data));
    end
    results_owed = queued_results.size();
    frame_busy = (phase_q != PH_IDLE);
  end

endmodule

// ===== tb/tb_ir_pulse_distance_transmitter_top.sv =====
module tb_ir_pulse_distance_transmitter_top;
  import irpdt_pkg::*;

  localparam int FRAME_BITS   = FRAME_BITS_DEF;
  localparam int RANDOM_REQS  = 1100;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   fail_total;
  int   results_owed;
  logic frame_busy;

  int   req_count = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;

  ir_pulse_distance_transmitter_top #(.FRAME_BITS(FRAME_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ir_frame_monitor #(.FRAME_BITS(FRAME_BITS)) u_frame_monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_total   (fail_total),
    .results_owed (results_owed),
    .frame_busy   (frame_busy)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap(int busy_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= busy_pct) return 0;
    if (roll >= 4) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] short_len();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 4) return '0;
    if (roll < 18) return 16'($urandom_range(1, 2));
    return 16'($urandom_range(3, 12));
  endfunction

  // Short segments keep frames near a hundred ticks
  function automatic cfg_t random_timing();
    cfg_t timing;
    timing.half_period  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 4));
    timing.bit_mark     = short_len();
    timing.one_space    = short_len();
    timing.zero_space   = short_len();
    timing.header_mark  = short_len();
    timing.header_space = short_len();
    timing.stop_mark    = short_len();
    if ($urandom_range(0, 19) == 0) begin
      timing.bit_mark     = '0;
      timing.one_space    = '0;
      timing.zero_space   = '0;
      timing.header_mark  = '0;
      timing.header_space = '0;
      timing.stop_mark    = '0;
    end
    return timing;
  endfunction

  // Hold the request until the block takes it
  task automatic send_req(input logic op, input logic [15:0] addr, input logic [15:0] cmd);
    int gap;
    gap = in_calm ? 0 : draw_gap(30);
    if ($urandom_range(0, 299) == 0) in_calm = ~in_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, address: addr, command: cmd};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    req_count++;
  endtask

  task automatic send_tick();
    send_req(OP_TICK, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_start();
    send_req(OP_START, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  // Tick until the frame is out, with stray starts that must be refused
  task automatic finish_frame();
    while (frame_busy) begin
      if ($urandom_range(0, 39) == 0) send_random_start();
      else send_tick();
    end
  endtask

  task automatic run_frame(input logic [15:0] addr, input logic [15:0] cmd);
    send_req(OP_START, addr, cmd);
    finish_frame();
  endtask

  // Drop valid and wait until every result is back
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Write all timing registers; junk in the upper byte of the half period
  task automatic load_config(input cfg_t timing);
    write_reg(REG_HALF_PERIOD, {8'($urandom_range(0, 255)), timing.half_period});
    write_reg(REG_BIT_MARK, timing.bit_mark);
    write_reg(REG_ONE_SPACE, timing.one_space);
    write_reg(REG_ZERO_SPACE, timing.zero_space);
    write_reg(REG_HEADER_MARK, timing.header_mark);
    write_reg(REG_HEADER_SPACE, timing.header_space);
    write_reg(REG_STOP_MARK, timing.stop_mark);
    cfg_we <= 1'b0;
  endtask

  // Release the result side in bursts with random stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= out_calm ? 0 : draw_gap(20);
    end
    if ($urandom_range(0, 399) == 0) out_calm <= ~out_calm;
  end

  // Abort when no request moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ir_pulse_distance_transmitter_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Ticks while idle give all-zero results
    send_tick();
    send_tick();
    settle_idle();

    // Half period of zero, zero stop mark, extreme frame data, refused start
    write_reg(REG_UNUSED, 16'hFFFF);
    load_config('{8'd0, 16'd1, 16'd2, 16'd1, 16'd1, 16'd1, 16'd0});
    send_req(OP_START, 16'hFFFF, 16'h0000);
    send_req(OP_START, 16'h0000, 16'hFFFF);
    finish_frame();
    settle_idle();

    // All segments empty: the frame completes on the start itself
    load_config('{8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_req(OP_START, 16'h8001, 16'h7FFE);
    send_req(OP_START, 16'hFFFF, 16'hFFFF);
    send_tick();
    settle_idle();

    // Empty bit marks and zero spaces skipped inside the frame
    load_config('{8'd2, 16'd0, 16'd3, 16'd0, 16'd0, 16'd2, 16'd3});
    run_frame(16'h0000, 16'hFFFF);
    settle_idle();

    // Long mark at the slowest carrier
    load_config('{8'd255, 16'd0, 16'd0, 16'd0, 16'd300, 16'd0, 16'd0});
    run_frame(16'hA5A5, 16'h5A5A);
    settle_idle();

    // Random timing sets, one frame each
    while (req_count < RANDOM_REQS) begin
      load_config(random_timing());
      repeat ($urandom_range(0, 2)) send_tick();
      run_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      settle_idle();
    end

    if (fail_total == 0 && results_owed == 0)
      $display("ir_pulse_distance_transmitter_top verification clean");
    else
      $display("ir_pulse_distance_transmitter_top verification failed");
    $finish;
  end

endmodule
